/* sv/mbrm_pkg.sv */
// Shared types and constants of the Modbus RTU master register mirror.
// Holds command, status, function and frame codes and the CRC control type.
// No dependencies.
`timescale 1ns / 1ps

package mbrm_pkg;

	// Item kinds on the input stream.
	localparam logic [1:0] CMD_READ   = 2'd0;
	localparam logic [1:0] CMD_WRITE  = 2'd1;
	localparam logic [1:0] CMD_RX     = 2'd2;
	localparam logic [1:0] CMD_MIRROR = 2'd3;

	// Status codes of a result item.
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BUSY    = 3'd1;
	localparam logic [2:0] ST_ACCEPT  = 3'd2;
	localparam logic [2:0] ST_CRC_BAD = 3'd3;
	localparam logic [2:0] ST_IGNORED = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SLAVE     = 2'd0;
	localparam logic [1:0] CFG_BASE      = 2'd1;
	localparam logic [1:0] CFG_LAST_OFS  = 2'd2;
	localparam logic [1:0] CFG_REF_LIMIT = 2'd3;

	// Modbus function codes.
	localparam logic [7:0] FC_READ  = 8'h03;
	localparam logic [7:0] FC_WRITE = 8'h06;

	// CRC-16/Modbus.
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Byte positions within a response frame.
	localparam int POS_FC    = 1;
	localparam int POS_BYTES = 2;
	localparam int POS_DATA  = 3;
	localparam int POS_VALUE = 4;

	// Lengths of response frames.
	localparam logic [7:0] RESP_OVERHEAD  = 8'd5;
	localparam logic [7:0] WRITE_RESP_LEN = 8'd8;
	localparam logic [8:0] WRITE_CRC_LEN  = 9'd6;

	// Control of the bit-serial CRC unit.
	typedef struct packed {
		logic       init;
		logic       load;
		logic       step;
		logic [7:0] data;
	} crc_ctrl_t;

endpackage

/* sv/modbus_rtu_master_register_mirror.sv */
// Top level of the Modbus RTU master with a register mirror.
// Depends on mbrm_pkg, mbrm_ram and mbrm_crc_serial.
//
// Use: items enter on the s_ stream; s_tuser carries the command (read request,
// write single request, received byte, read mirror word). Results leave on the
// m_ stream. A request gives eight frame transactions (m_tuser high, m_tlast on
// the eighth); every other item gives one status transaction.
// Flow: an item is taken only while the sequencer is idle. After a request the
// next item waits until its last frame byte has left the sequencer: the CRC over
// six bytes runs one bit a cycle, each byte loaded first, then one frame byte
// leaves per cycle while the output register is free. A byte that ends a frame walks
// the receive memory through one read port, with a wait state after each fetch
// and one CRC step per bit of each checked byte.
// Reset clears the sequencer, counters and the mirror to zero and sets the
// configuration to its defaults; the receive memory is not cleared.
// A stalled receiver holds the output register; the sequencer waits for it.
`timescale 1ns / 1ps

module modbus_rtu_master_register_mirror #(
	parameter int RX_DEPTH     = 64,
	parameter int MIRROR_WORDS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // reg_address[15:0], word_value[31:16], rx_byte[39:32],
	                              // mirror_index[42:40], zero fill
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // tx_byte[7:0], status[10:8], mirror_word[26:11],
	                              // pending[27], zero fill
	output logic        m_tuser,  // tx_valid
	output logic        m_tlast   // tx_last
);

	import mbrm_pkg::*;

	localparam int AW   = $clog2(RX_DEPTH);
	localparam int CW   = $clog2(RX_DEPTH + 1);
	localparam int MW_W = $clog2(MIRROR_WORDS);
	localparam logic [AW-1:0] ADDR_LAST = AW'(RX_DEPTH - 1);

	// Sequencer codes.
	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DISP  = 5'd1;
	localparam logic [4:0] S_OUT   = 5'd2;
	localparam logic [4:0] S_TXLD  = 5'd3;
	localparam logic [4:0] S_TXBIT = 5'd4;
	localparam logic [4:0] S_TXOUT = 5'd5;
	localparam logic [4:0] S_RWAIT = 5'd6;
	localparam logic [4:0] S_FC    = 5'd7;
	localparam logic [4:0] S_DL    = 5'd8;
	localparam logic [4:0] S_R2    = 5'd9;
	localparam logic [4:0] S_R3    = 5'd10;
	localparam logic [4:0] S_CRCLD = 5'd11;
	localparam logic [4:0] S_CRCBT = 5'd12;
	localparam logic [4:0] S_GOTLO = 5'd13;
	localparam logic [4:0] S_GOTHI = 5'd14;
	localparam logic [4:0] S_WHI   = 5'd15;
	localparam logic [4:0] S_WLO   = 5'd16;
	localparam logic [4:0] S_DONE  = 5'd17;

	function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
		if (a == ADDR_LAST) begin
			return '0;
		end
		return a + AW'(1);
	endfunction

	// Configuration registers.
	logic [7:0]  slave_q;
	logic [15:0] base_q;
	logic [2:0]  last_ofs_q;
	logic [3:0]  ref_limit_q;

	// Sequencer and item registers.
	logic [4:0]  state_q, ret_q;
	logic [1:0]  cmd_q;
	logic [15:0] reg_q, val_q;
	logic [7:0]  rxb_q;
	logic [2:0]  mi_q;
	logic [7:0]  fc_q, dl_q, gl_q, hi_q;
	logic [2:0]  k_q, bit_q;
	logic [8:0]  j_q, n_q;
	logic [6:0]  i_q;
	logic [2:0]  st_q;
	logic [15:0] mw_q;
	logic [AW-1:0] rd_addr_q;

	// Protocol state.
	logic [CW-1:0] rx_count_q;
	logic [7:0]    exp_q;
	logic          pend_q;
	logic [15:0]   pstart_q;
	logic [3:0]    refuse_q;
	logic [15:0]   mirror_q [MIRROR_WORDS];

	// Output register.
	logic        m_tvalid_q, m_tlast_q, m_tuser_q;
	logic [7:0]  o_txb_q;
	logic [2:0]  o_st_q;
	logic [15:0] o_mw_q;
	logic        o_pend_q;

	logic          out_free;
	logic          out_load;
	logic [CW-1:0] cnt_w, cnt_n;
	logic [4:0]    ref_n;
	logic [7:0]    len_sat;
	logic [15:0]   off16;
	logic [7:0]    idx8;
	logic [MW_W+7:0] idx_wide;
	logic [MW_W+2:0] mi_wide;
	logic [15:0]   mirror_rd;
	logic [7:0]    tx_sel;
	logic [15:0]   crc;
	logic [7:0]    ram_rdata;
	logic          ram_we;
	crc_ctrl_t     crc_ctrl;

	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = out_free && ((state_q == S_OUT) || (state_q == S_TXOUT));

	// Receive position after the wrap at the memory depth.
	assign cnt_w = (rx_count_q >= CW'(RX_DEPTH)) ? '0 : rx_count_q;
	assign cnt_n = cnt_w + CW'(1);
	assign ref_n = {1'b0, refuse_q} + 5'd1;
	assign len_sat = (val_q > 16'd125) ? 8'd255 : ({val_q[6:0], 1'b0} + RESP_OVERHEAD);

	// Mirror offsets and the selected word of a mirror read.
	assign off16    = pstart_q - base_q;
	assign idx8     = {1'b0, i_q} + {5'd0, off16[2:0]};
	assign idx_wide = {{MW_W{1'b0}}, idx8};
	assign mi_wide  = {{MW_W{1'b0}}, mi_q};
	assign mirror_rd = ({29'd0, mi_q} < 32'(MIRROR_WORDS)) ? mirror_q[mi_wide[MW_W-1:0]]
	                                                        : 16'd0;

	// Request frame byte selected by the byte counter.
	always_comb begin
		case (k_q)
			3'd0: tx_sel = slave_q;
			3'd1: tx_sel = fc_q;
			3'd2: tx_sel = reg_q[15:8];
			3'd3: tx_sel = reg_q[7:0];
			3'd4: tx_sel = val_q[15:8];
			3'd5: tx_sel = val_q[7:0];
			3'd6: tx_sel = crc[7:0];
			default: tx_sel = crc[15:8];
		endcase
	end

	// CRC unit control.
	always_comb begin
		crc_ctrl.init = (state_q == S_DISP) || (state_q == S_DL) || (state_q == S_R3);
		crc_ctrl.load = (state_q == S_TXLD) || (state_q == S_CRCLD);
		crc_ctrl.step = (state_q == S_TXBIT) || (state_q == S_CRCBT);
		crc_ctrl.data = (state_q == S_CRCLD) ? ram_rdata : tx_sel;
	end

	assign ram_we = (state_q == S_DISP) && (cmd_q == CMD_RX) && pend_q;

	mbrm_crc_serial u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.crc    (crc)
	);

	mbrm_ram #(
		.WIDTH (8),
		.DEPTH (RX_DEPTH)
	) u_rx_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_w[AW-1:0]),
		.wdata (rxb_q),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q     <= 8'd1;
			base_q      <= 16'd0;
			last_ofs_q  <= 3'd6;
			ref_limit_q <= 4'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SLAVE:     slave_q     <= cfg_data[7:0];
				CFG_BASE:      base_q      <= cfg_data;
				CFG_LAST_OFS:  last_ofs_q  <= cfg_data[2:0];
				CFG_REF_LIMIT: ref_limit_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Item capture, request emission and frame checking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ret_q      <= S_IDLE;
			rx_count_q <= '0;
			exp_q      <= 8'd0;
			pend_q     <= 1'b0;
			pstart_q   <= 16'd0;
			refuse_q   <= 4'd0;
			m_tvalid_q <= 1'b0;
			for (int w = 0; w < MIRROR_WORDS; w++) begin
				mirror_q[w] <= 16'd0;
			end
		end else begin
			if (m_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= s_tuser;
						reg_q   <= s_tdata[15:0];
						val_q   <= s_tdata[31:16];
						rxb_q   <= s_tdata[39:32];
						mi_q    <= s_tdata[42:40];
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					mw_q <= 16'd0;
					st_q <= ST_OK;
					case (cmd_q)
						CMD_READ: begin
							if (pend_q) begin
								if (ref_n > {1'b0, ref_limit_q}) begin
									pend_q   <= 1'b0;
									pstart_q <= 16'd0;
									refuse_q <= 4'd0;
								end else begin
									refuse_q <= ref_n[3:0];
								end
								st_q    <= ST_BUSY;
								state_q <= S_OUT;
							end else begin
								exp_q      <= len_sat;
								pend_q     <= 1'b1;
								pstart_q   <= reg_q;
								rx_count_q <= '0;
								fc_q       <= FC_READ;
								k_q        <= 3'd0;
								state_q    <= S_TXLD;
							end
						end
						CMD_WRITE: begin
							exp_q      <= WRITE_RESP_LEN;
							pend_q     <= 1'b1;
							pstart_q   <= reg_q;
							rx_count_q <= '0;
							fc_q       <= FC_WRITE;
							k_q        <= 3'd0;
							state_q    <= S_TXLD;
						end
						CMD_RX: begin
							if (!pend_q) begin
								st_q    <= ST_IGNORED;
								state_q <= S_OUT;
							end else begin
								rx_count_q <= cnt_n;
								if (9'(cnt_n) >= {1'b0, exp_q}) begin
									rd_addr_q <= AW'(POS_FC);
									ret_q     <= S_FC;
									state_q   <= S_RWAIT;
								end else begin
									state_q <= S_OUT;
								end
							end
						end
						default: begin
							mw_q    <= mirror_rd;
							state_q <= S_OUT;
						end
					endcase
				end
				S_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= 1'b0;
						m_tlast_q  <= 1'b0;
						o_txb_q    <= 8'd0;
						o_st_q     <= st_q;
						o_mw_q     <= mw_q;
						o_pend_q   <= pend_q;
						state_q    <= S_IDLE;
					end
				end
				// CRC over the six header bytes, one bit a cycle.
				S_TXLD: begin
					bit_q   <= 3'd0;
					state_q <= S_TXBIT;
				end
				S_TXBIT: begin
					bit_q <= bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						if (k_q == 3'd5) begin
							k_q     <= 3'd0;
							state_q <= S_TXOUT;
						end else begin
							k_q     <= k_q + 3'd1;
							state_q <= S_TXLD;
						end
					end
				end
				S_TXOUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= 1'b1;
						m_tlast_q  <= (k_q == 3'd7);
						o_txb_q    <= tx_sel;
						o_st_q     <= ST_OK;
						o_mw_q     <= 16'd0;
						o_pend_q   <= pend_q;
						k_q        <= k_q + 3'd1;
						if (k_q == 3'd7) begin
							state_q <= S_IDLE;
						end
					end
				end
				// The memory read started by the previous state completes here.
				S_RWAIT: begin
					state_q <= ret_q;
				end
				S_FC: begin
					fc_q <= ram_rdata;
					if (ram_rdata == FC_READ) begin
						rd_addr_q <= AW'(POS_BYTES);
						ret_q     <= S_DL;
						state_q   <= S_RWAIT;
					end else if (ram_rdata == FC_WRITE) begin
						rd_addr_q <= AW'(POS_BYTES);
						ret_q     <= S_R2;
						state_q   <= S_RWAIT;
					end else begin
						st_q    <= ST_IGNORED;
						state_q <= S_DONE;
					end
				end
				S_DL: begin
					dl_q      <= ram_rdata;
					n_q       <= {1'b0, ram_rdata} + 9'(POS_DATA);
					j_q       <= 9'd0;
					rd_addr_q <= '0;
					ret_q     <= S_CRCLD;
					state_q   <= S_RWAIT;
				end
				S_R2: begin
					hi_q      <= ram_rdata;
					rd_addr_q <= AW'(POS_DATA);
					ret_q     <= S_R3;
					state_q   <= S_RWAIT;
				end
				S_R3: begin
					if ({hi_q, ram_rdata} != pstart_q) begin
						st_q    <= ST_IGNORED;
						state_q <= S_DONE;
					end else begin
						n_q       <= WRITE_CRC_LEN;
						j_q       <= 9'd0;
						rd_addr_q <= '0;
						ret_q     <= S_CRCLD;
						state_q   <= S_RWAIT;
					end
				end
				// CRC over the received bytes, one bit a cycle.
				S_CRCLD: begin
					bit_q   <= 3'd0;
					state_q <= S_CRCBT;
				end
				S_CRCBT: begin
					bit_q <= bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						j_q       <= j_q + 9'd1;
						rd_addr_q <= next_addr(rd_addr_q);
						ret_q     <= (j_q + 9'd1 == n_q) ? S_GOTLO : S_CRCLD;
						state_q   <= S_RWAIT;
					end
				end
				S_GOTLO: begin
					gl_q      <= ram_rdata;
					rd_addr_q <= next_addr(rd_addr_q);
					ret_q     <= S_GOTHI;
					state_q   <= S_RWAIT;
				end
				S_GOTHI: begin
					if ({ram_rdata, gl_q} != crc) begin
						st_q    <= ST_CRC_BAD;
						state_q <= S_DONE;
					end else begin
						st_q <= ST_ACCEPT;
						i_q  <= 7'd0;
						if (fc_q == FC_WRITE) begin
							rd_addr_q <= AW'(POS_VALUE);
							ret_q     <= S_WHI;
							state_q   <= S_RWAIT;
						end else if ((off16 <= {13'd0, last_ofs_q}) && (dl_q[7:1] != 7'd0)) begin
							rd_addr_q <= AW'(POS_DATA);
							ret_q     <= S_WHI;
							state_q   <= S_RWAIT;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				// Returned words, high byte first, into the mirror.
				S_WHI: begin
					hi_q      <= ram_rdata;
					rd_addr_q <= next_addr(rd_addr_q);
					ret_q     <= S_WLO;
					state_q   <= S_RWAIT;
				end
				S_WLO: begin
					if (fc_q == FC_WRITE) begin
						if (off16 < 16'(MIRROR_WORDS)) begin
							mirror_q[off16[MW_W-1:0]] <= {hi_q, ram_rdata};
						end
						state_q <= S_DONE;
					end else begin
						if ({24'd0, idx8} < 32'(MIRROR_WORDS)) begin
							mirror_q[idx_wide[MW_W-1:0]] <= {hi_q, ram_rdata};
						end
						if ({1'b0, i_q} + 8'd1 < {1'b0, dl_q[7:1]}) begin
							i_q       <= i_q + 7'd1;
							rd_addr_q <= next_addr(rd_addr_q);
							ret_q     <= S_WHI;
							state_q   <= S_RWAIT;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					exp_q      <= 8'd0;
					pstart_q   <= 16'd0;
					refuse_q   <= 4'd0;
					rx_count_q <= '0;
					pend_q     <= 1'b0;
					mw_q       <= 16'd0;
					state_q    <= S_OUT;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = {4'd0, o_pend_q, o_mw_q, o_st_q, o_txb_q};

	// The last flag only ever marks a frame byte.
	a_last_is_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("tlast on a status transaction");

	// Frame bytes are sent while the request is pending.
	a_frame_pending: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[27])
		else $error("frame byte without a pending request");

	// The receive count never passes the memory depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rx_count_q <= CW'(RX_DEPTH))
		else $error("receive count beyond depth");

	// A stored received byte always leaves the receive count above zero.
	a_store_pending: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (rx_count_q != '0))
		else $error("receive count not advanced after a store");

endmodule

/* sv/mbrm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mbrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/mbrm_crc_serial.sv */
// Bit-serial CRC-16/Modbus unit: one bit of a loaded byte per step.
// Depends on mbrm_pkg for the control type and the polynomial.
`timescale 1ns / 1ps

module mbrm_crc_serial (
	input  logic               clk,
	input  logic               arst_n,
	input  mbrm_pkg::crc_ctrl_t ctrl,
	output logic [15:0]        crc
);

	import mbrm_pkg::*;

	logic [15:0] crc_q;
	logic [7:0]  sh_q;
	logic        fb;

	assign fb = crc_q[0] ^ sh_q[0];

	// One reflected shift per step; the byte shifts out from its low bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			sh_q  <= 8'd0;
		end else begin
			if (ctrl.init) begin
				crc_q <= CRC_INIT;
			end else if (ctrl.step) begin
				crc_q <= (crc_q >> 1) ^ (fb ? CRC_POLY : 16'd0);
			end
			if (ctrl.load) begin
				sh_q <= ctrl.data;
			end else if (ctrl.step) begin
				sh_q <= sh_q >> 1;
			end
		end
	end

	assign crc = crc_q;

endmodule

/* test/modbus_rtu_master_register_mirror_test.sv */
// Testbench of the Modbus RTU master register mirror: directed and random traffic.
// It predicts every result transaction and checks each one against the block's output.
// Depends on mbrm_pkg and modbus_rtu_master_register_mirror.
`timescale 1ns / 1ps

module modbus_rtu_master_register_mirror_test;
	import mbrm_pkg::*;

	localparam int STORE_DEPTH = 64;
	localparam int MIRROR_SIZE = 8;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 40;

	// Frame corruption kinds used by the response builder.
	typedef enum int {RESP_GOOD, RESP_BAD_CRC, RESP_BAD_FC, RESP_BAD_FIELD} resp_kind_t;

	typedef struct packed {
		logic [7:0]  tx_byte;
		logic        tx_valid;
		logic        tx_last;
		logic [2:0]  status;
		logic [15:0] mirror_word;
		logic        pending;
	} master_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	// Predicted state of the master.
	logic [7:0]  slave_addr;
	logic [15:0] base_addr;
	logic [2:0]  last_offset;
	logic [3:0]  refusal_limit;
	logic [7:0]  rx_mem [STORE_DEPTH];
	int          rx_fill;
	logic [7:0]  resp_len;
	logic        req_pending;
	logic [15:0] req_start;
	logic [3:0]  refusals;
	logic [15:0] mirror_copy [MIRROR_SIZE];

	master_result_t expected_results[$];
	int mismatches;
	int cycle_count;
	int items_sent;
	int hold_cycles;
	bit calm;

	modbus_rtu_master_register_mirror dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	// Clock with a 10 ns period.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Bitwise CRC-16/Modbus update over one byte.
	function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic logic [7:0] rx_at(int i);
		return rx_mem[i % STORE_DEPTH];
	endfunction

	function automatic logic [15:0] crc_of_store(int n);
		logic [15:0] c;
		c = CRC_INIT;
		for (int i = 0; i < n; i++)
			c = crc_byte(c, rx_at(i));
		return c;
	endfunction

	task automatic push_result(logic [7:0] txb, logic tv, logic tl, logic [2:0] st,
			logic [15:0] mw);
		master_result_t r;
		r = '{txb, tv, tl, st, mw, req_pending};
		expected_results.push_back(r);
	endtask

	// Expected eight request bytes, CRC low byte first.
	task automatic predict_frame(logic [7:0] fc, logic [15:0] reg_a, logic [15:0] val);
		logic [7:0]  f [8];
		logic [15:0] c;
		f[0] = slave_addr;
		f[1] = fc;
		f[2] = reg_a[15:8];
		f[3] = reg_a[7:0];
		f[4] = val[15:8];
		f[5] = val[7:0];
		c = CRC_INIT;
		for (int i = 0; i < 6; i++)
			c = crc_byte(c, f[i]);
		f[6] = c[7:0];
		f[7] = c[15:8];
		for (int i = 0; i < 8; i++)
			push_result(f[i], 1'b1, i == 7, ST_OK, 16'h0000);
	endtask

	// Checks a completed response, updates the mirror and clears the request.
	function automatic logic [2:0] close_frame();
		logic [2:0]  st;
		logic [7:0]  fc;
		int          dl;
		logic [15:0] got;
		logic [15:0] ofs;
		logic [15:0] echo;
		st = ST_IGNORED;
		fc = rx_at(POS_FC);
		if (fc == FC_READ) begin
			dl = rx_at(POS_BYTES);
			got = {rx_at(4 + dl), rx_at(3 + dl)};
			if (got == crc_of_store(dl + 3)) begin
				st = ST_ACCEPT;
				ofs = req_start - base_addr;
				if (ofs <= {13'd0, last_offset}) begin
					for (int i = 0; i < dl / 2; i++)
						if (i + ofs < MIRROR_SIZE)
							mirror_copy[i + ofs] = {rx_at(3 + 2 * i), rx_at(4 + 2 * i)};
				end
			end else begin
				st = ST_CRC_BAD;
			end
		end else if (fc == FC_WRITE) begin
			echo = {rx_at(2), rx_at(3)};
			if (echo == req_start) begin
				got = {rx_at(7), rx_at(6)};
				if (got == crc_of_store(6)) begin
					st = ST_ACCEPT;
					ofs = echo - base_addr;
					if (ofs < MIRROR_SIZE)
						mirror_copy[ofs] = {rx_at(4), rx_at(5)};
				end else begin
					st = ST_CRC_BAD;
				end
			end
		end
		resp_len = 8'd0;
		req_start = 16'h0000;
		refusals = 4'd0;
		rx_fill = 0;
		req_pending = 1'b0;
		return st;
	endfunction

	// Works out the results of one accepted item.
	task automatic predict_item(logic [1:0] cmd, logic [15:0] reg_a, logic [15:0] val,
			logic [7:0] b, logic [2:0] mi);
		int len;
		logic [2:0] st;
		case (cmd)
			CMD_READ: begin
				if (req_pending) begin
					if (refusals + 1 > refusal_limit) begin
						req_pending = 1'b0;
						req_start = 16'h0000;
						refusals = 4'd0;
					end else begin
						refusals = refusals + 4'd1;
					end
					push_result(8'h00, 1'b0, 1'b0, ST_BUSY, 16'h0000);
				end else begin
					len = int'(val) * 2 + 5;
					resp_len = (len > 255) ? 8'd255 : len[7:0];
					req_pending = 1'b1;
					req_start = reg_a;
					rx_fill = 0;
					predict_frame(FC_READ, reg_a, val);
				end
			end
			CMD_WRITE: begin
				resp_len = WRITE_RESP_LEN;
				req_pending = 1'b1;
				req_start = reg_a;
				rx_fill = 0;
				predict_frame(FC_WRITE, reg_a, val);
			end
			CMD_RX: begin
				st = ST_OK;
				if (!req_pending) begin
					st = ST_IGNORED;
				end else begin
					if (rx_fill >= STORE_DEPTH)
						rx_fill = 0;
					rx_mem[rx_fill % STORE_DEPTH] = b;
					rx_fill++;
					if (rx_fill >= resp_len)
						st = close_frame();
				end
				push_result(8'h00, 1'b0, 1'b0, st, 16'h0000);
			end
			default: begin
				push_result(8'h00, 1'b0, 1'b0, ST_OK, mirror_copy[mi]);
			end
		endcase
	endtask

	// Offers one item, with random idle cycles first unless calm, and waits until it is taken.
	task automatic send_item(logic [1:0] cmd, logic [15:0] reg_a, logic [15:0] val,
			logic [7:0] b, logic [2:0] mi);
		while (!calm && $urandom_range(99) < 32) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {5'd0, mi, b, val, reg_a};
		do
			@(posedge clk);
		while (!s_tready);
		predict_item(cmd, reg_a, val, b, mi);
		items_sent++;
	endtask

	// Waits until every expected result has arrived and the block has gone quiet.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_SLAVE:    slave_addr = value[7:0];
			CFG_BASE:     base_addr = value;
			CFG_LAST_OFS: last_offset = value[2:0];
			default:      refusal_limit = value[3:0];
		endcase
	endtask

	task automatic configure(logic [7:0] sa, logic [15:0] base, logic [2:0] lo,
			logic [3:0] lim);
		settle();
		write_cfg(CFG_SLAVE, {8'd0, sa});
		write_cfg(CFG_BASE, base);
		write_cfg(CFG_LAST_OFS, {13'd0, lo});
		write_cfg(CFG_REF_LIMIT, {12'd0, lim});
	endtask

	// Sends a response frame to the pending request, corrupted as asked.
	task automatic send_response(bit is_read, logic [15:0] reg_a, logic [15:0] val,
			resp_kind_t kind);
		logic [7:0]  bytes[$];
		logic [15:0] c;
		bytes.push_back(slave_addr);
		bytes.push_back(is_read ? FC_READ : FC_WRITE);
		if (is_read) begin
			bytes.push_back(kind == RESP_BAD_FIELD ? 8'($urandom) : 8'(val * 2));
			for (int i = 0; i < 2 * val; i++)
				bytes.push_back(8'($urandom));
		end else begin
			bytes.push_back(reg_a[15:8]);
			bytes.push_back(kind == RESP_BAD_FIELD ? reg_a[7:0] ^ 8'h01 : reg_a[7:0]);
			bytes.push_back(val[15:8]);
			bytes.push_back(val[7:0]);
		end
		if (kind == RESP_BAD_FC)
			bytes[1] = 8'($urandom_range(7, 255));
		c = CRC_INIT;
		foreach (bytes[i])
			c = crc_byte(c, bytes[i]);
		if (kind == RESP_BAD_CRC)
			c[$urandom_range(15)] ^= 1'b1;
		bytes.push_back(c[7:0]);
		bytes.push_back(c[15:8]);
		foreach (bytes[i])
			send_item(CMD_RX, 16'($urandom), 16'($urandom), bytes[i], 3'($urandom));
	endtask

	// Fills every receive entry once, so that later frame checks read written data.
	task automatic test_store_priming();
		send_item(CMD_READ, 16'h1234, 16'd40, 8'h00, 3'd0);
		for (int i = 0; i < STORE_DEPTH; i++)
			send_item(CMD_RX, 16'h0000, 16'h0000,
				(i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom), 3'd0);
		settle();
	endtask

	// Extremes, refusals, stray bytes and each kind of response.
	task automatic test_directed();
		send_item(CMD_WRITE, 16'h0000, 16'hFFFF, 8'h00, 3'd7);
		send_response(1'b0, 16'h0000, 16'hFFFF, RESP_GOOD);
		send_item(CMD_RX, 16'hFFFF, 16'hFFFF, 8'hFF, 3'd7);
		send_item(CMD_MIRROR, 16'h0000, 16'h0000, 8'h00, 3'd0);
		send_item(CMD_MIRROR, 16'hFFFF, 16'hFFFF, 8'hFF, 3'd7);
		send_item(CMD_READ, 16'hFFFF, 16'hFFFF, 8'h00, 3'd0);
		repeat (3) send_item(CMD_READ, 16'h0001, 16'h0001, 8'h00, 3'd0);
		send_item(CMD_READ, 16'h0001, 16'd8, 8'h00, 3'd0);
		send_item(CMD_WRITE, 16'h0002, 16'h5A5A, 8'h00, 3'd0);
		send_response(1'b0, 16'h0002, 16'h5A5A, RESP_BAD_FIELD);
		send_item(CMD_READ, 16'h0000, 16'd0, 8'h00, 3'd0);
		send_response(1'b1, 16'h0000, 16'd0, RESP_BAD_CRC);
		send_item(CMD_READ, 16'h0000, 16'd2, 8'h00, 3'd0);
		send_response(1'b1, 16'h0000, 16'd2, RESP_BAD_FC);
		settle();
	endtask

	// One request and usually its response, mostly well formed, near the mirror window.
	task automatic random_exchange();
		bit          is_read;
		logic [15:0] reg_a;
		logic [15:0] val;
		int          pick;
		resp_kind_t  kind;
		is_read = $urandom_range(1);
		reg_a = ($urandom_range(3) == 0) ? 16'($urandom) :
			16'(base_addr + 16'($urandom_range(9)));
		if (is_read)
			val = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(8));
		else
			val = 16'($urandom);
		send_item(is_read ? CMD_READ : CMD_WRITE, reg_a, val, 8'($urandom), 3'($urandom));
		if ($urandom_range(5) == 0)
			repeat ($urandom_range(1, 3))
				send_item(CMD_READ, 16'($urandom), 16'($urandom), 8'($urandom), 3'($urandom));
		pick = $urandom_range(9);
		kind = (pick < 7) ? RESP_GOOD : (pick == 7) ? RESP_BAD_CRC :
			(pick == 8) ? RESP_BAD_FC : RESP_BAD_FIELD;
		if (is_read && val > 8) begin
			repeat ($urandom_range(1, 10))
				send_item(CMD_RX, 16'($urandom), 16'($urandom), 8'($urandom), 3'($urandom));
		end else begin
			send_response(is_read, reg_a, val, kind);
		end
	endtask

	task automatic random_noise();
		send_item(2'($urandom), 16'($urandom), ($urandom_range(1) ? 16'($urandom_range(8)) :
			16'($urandom)), 8'($urandom), 3'($urandom));
	endtask

	task automatic test_random_phase(int target);
		while (items_sent < target) begin
			if ($urandom_range(9) < 7)
				random_exchange();
			else
				random_noise();
			if ($urandom_range(3) == 0)
				send_item(CMD_MIRROR, 16'($urandom), 16'($urandom), 8'($urandom),
					3'($urandom));
		end
	endtask

	// The receiver holds off while requests keep coming, so that the input stalls.
	task automatic test_backpressure();
		settle();
		hold_cycles = 400;
		send_item(CMD_WRITE, base_addr, 16'hA5C3, 8'h00, 3'd0);
		repeat (4) send_item(CMD_MIRROR, 16'h0000, 16'h0000, 8'h00, 3'($urandom));
		send_item(CMD_READ, base_addr, 16'd1, 8'h00, 3'd0);
		settle();
	endtask

	// Receiver side: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 32);
		end
	end

	// Compares each result transaction with the oldest prediction.
	always @(posedge clk) begin
		master_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result transaction: %h", m_tdata);
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[7:0] !== want.tx_byte || m_tuser !== want.tx_valid ||
						m_tlast !== want.tx_last || m_tdata[10:8] !== want.status ||
						m_tdata[26:11] !== want.mirror_word || m_tdata[27] !== want.pending ||
						m_tdata[31:28] !== 4'd0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch: expected byte %h valid %b last %b status %0d %s",
							want.tx_byte, want.tx_valid, want.tx_last, want.status,
							$sformatf("word %h pend %b", want.mirror_word, want.pending));
						$display("          got byte %h valid %b last %b status %0d %s",
							m_tdata[7:0], m_tuser, m_tlast, m_tdata[10:8],
							$sformatf("word %h pend %b", m_tdata[26:11], m_tdata[27]));
					end
				end
			end
		end
	end

	// Cycle counter that ends a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		cycle_count = 0;
		mismatches = 0;
		items_sent = 0;
		hold_cycles = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SLAVE;
		cfg_data = 16'h0000;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_READ;
		m_tready = 1'b0;
		slave_addr = 8'h01;
		base_addr = 16'h0000;
		last_offset = 3'd6;
		refusal_limit = 4'd2;
		rx_fill = 0;
		resp_len = 8'd0;
		req_pending = 1'b0;
		req_start = 16'h0000;
		refusals = 4'd0;
		foreach (rx_mem[i])
			rx_mem[i] = 8'h00;
		foreach (mirror_copy[i])
			mirror_copy[i] = 16'h0000;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_store_priming();
		test_directed();
		test_random_phase(items_sent + 25);
		configure(8'h00, 16'h0000, 3'd7, 4'd0);
		test_random_phase(items_sent + 25);
		configure(8'hFF, 16'hFFFF, 3'd0, 4'd15);
		calm = 1'b1;
		test_random_phase(items_sent + 25);
		calm = 1'b0;
		test_backpressure();
		configure(8'($urandom), 16'($urandom_range(0, 16)), 3'($urandom), 4'($urandom));
		test_random_phase(items_sent + 35);
		configure(8'h5A, 16'h8000, 3'd3, 4'd1);
		test_random_phase(items_sent + 25);
		settle();

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
